FILE: rtl/core/sfcc_pkg.sv
// ----------------------------------------------------------------------------
// Sensor frame CRC checker package
// Shared types, frame positions, status codes and CRC-8 constants.
// ----------------------------------------------------------------------------
package sfcc_pkg;

   typedef logic [7:0]  byte_type;
   typedef logic [7:0]  crc_type;
   typedef logic [2:0]  pos_type;
   typedef logic [1:0]  status_type;
   typedef logic [31:0] value_type;

   // CRC-8, polynomial x^8 + x^5 + x^4 + 1, MSB first, no final XOR
   localparam crc_type CRC_POLY = 8'h31;
   localparam crc_type CRC_INIT = 8'hFF;
   localparam crc_type CRC_MSB  = 8'h80;

   // frame_mode codes
   localparam logic MODE_MEASURE = 1'b0;
   localparam logic MODE_STATUS  = 1'b1;

   // byte positions within a frame
   localparam pos_type POS_W0_HI  = 3'd0;
   localparam pos_type POS_W0_LO  = 3'd1;
   localparam pos_type POS_W0_CRC = 3'd2;
   localparam pos_type POS_W1_HI  = 3'd3;
   localparam pos_type POS_W1_LO  = 3'd4;
   localparam pos_type POS_W1_CRC = 3'd5;

   // frame_status codes
   localparam status_type STATUS_OK         = 2'd0;
   localparam status_type STATUS_FIRST_BAD  = 2'd1;
   localparam status_type STATUS_SECOND_BAD = 2'd2;

endpackage

FILE: rtl/core/sfcc_channels.sv
// ----------------------------------------------------------------------------
// Sensor frame CRC checker channels
// Valid/ready interfaces for the received byte stream and the frame results.
// ----------------------------------------------------------------------------
interface sfcc_req_if
   import sfcc_pkg::*;
   ();
   logic     valid;
   logic     ready;
   byte_type rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sfcc_rsp_if
   import sfcc_pkg::*;
   ();
   logic       valid;
   logic       ready;
   status_type frame_status;
   value_type  frame_value;

   modport source (output valid, output frame_status, output frame_value, input ready);
   modport sink   (input valid, input frame_status, input frame_value, output ready);
endinterface

FILE: rtl/core/sensor_frame_crc_checker.sv
// ----------------------------------------------------------------------------
// Sensor frame CRC checker
// Checks each two-byte word of a sensor frame against its trailing CRC-8
// byte and returns one status/value result at the end of every frame.
// ----------------------------------------------------------------------------
// Result path: a result is registered; the last byte of its frame sits in the
//   input register, then the result register loads once it is free or being
//   emptied.
// Throughput: one byte per cycle while the result register is free or being
//   emptied, with a combinational CRC byte update; one result per frame (every
//   sixth byte in measurement mode, every third in status mode).
// Reset: synchronous, active high; measurement mode, empty frame, CRC 0xFF.
// ----------------------------------------------------------------------------
module sensor_frame_crc_checker
   import sfcc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic        csr_wr_data,
   sfcc_req_if.sink    req_chan,
   sfcc_rsp_if.source  rsp_chan
);

   // configuration
   logic mode_ff, mode_in;

   // input register
   logic     s1_valid_ff, s1_valid_in;
   byte_type s1_byte_ff;

   // frame state
   crc_type   crc_ff, crc_in;
   pos_type   pos_ff, pos_in;
   value_type words_ff, words_in;
   logic      first_bad_ff, first_bad_in;

   // result register
   logic       rsp_valid_ff, rsp_valid_in;
   status_type rsp_status_ff, rsp_status_in;
   value_type  rsp_value_ff, rsp_value_in;

   logic    advance;
   logic    step;
   logic    emit;
   logic    crc_match;
   logic    is_data;
   crc_type crc_upd;

   sfcc_crc8_step u_crc (
      .crc_cur   (crc_ff),
      .data_byte (s1_byte_ff),
      .crc_nxt   (crc_upd)
   );

   // Advance the input register whenever the result register is free or
   // being emptied this cycle; a waiting result does not stop one more byte
   // from being taken into the input register.
   assign advance       = !rsp_valid_ff || rsp_chan.ready;
   assign step          = s1_valid_ff && advance;
   assign req_chan.ready = !s1_valid_ff || advance;

   assign s1_valid_in = req_chan.valid ? 1'b1 : (s1_valid_ff && !advance);

   assign crc_match = (crc_ff == s1_byte_ff);
   assign is_data   = (pos_ff inside {POS_W0_HI, POS_W0_LO}) ||
                      (mode_ff == MODE_MEASURE && (pos_ff inside {POS_W1_HI, POS_W1_LO}));

   // Frame sequencing: collect data bytes, compare CRC bytes, emit at frame end.
   always_comb begin
      mode_in       = mode_ff;
      crc_in        = crc_ff;
      pos_in        = pos_ff;
      words_in      = words_ff;
      first_bad_in  = first_bad_ff;
      emit          = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;

      if (csr_wr_en) begin
         // a mode write abandons any frame in progress
         mode_in      = csr_wr_data;
         crc_in       = CRC_INIT;
         pos_in       = POS_W0_HI;
         words_in     = '0;
         first_bad_in = 1'b0;
      end else if (step) begin
         if (is_data) begin
            crc_in   = crc_upd;
            words_in = {words_ff[23:0], s1_byte_ff};
            pos_in   = pos_ff + 3'd1;
         end else if (pos_ff == POS_W0_CRC && mode_ff == MODE_STATUS) begin
            emit          = 1'b1;
            rsp_status_in = crc_match ? STATUS_OK : STATUS_FIRST_BAD;
            rsp_value_in  = crc_match ? {16'h0000, words_ff[15:0]} : '0;
            crc_in        = CRC_INIT;
            pos_in        = POS_W0_HI;
            words_in      = '0;
            first_bad_in  = 1'b0;
         end else if (pos_ff == POS_W0_CRC) begin
            // hold the first-word verdict until the frame closes
            first_bad_in = first_bad_ff || !crc_match;
            crc_in       = CRC_INIT;
            pos_in       = POS_W1_HI;
         end else if (pos_ff == POS_W1_CRC && mode_ff == MODE_MEASURE) begin
            emit = 1'b1;
            if (first_bad_ff) begin
               rsp_status_in = STATUS_FIRST_BAD;
               rsp_value_in  = '0;
            end else if (!crc_match) begin
               rsp_status_in = STATUS_SECOND_BAD;
               rsp_value_in  = '0;
            end else begin
               rsp_status_in = STATUS_OK;
               rsp_value_in  = words_ff;
            end
            crc_in       = CRC_INIT;
            pos_in       = POS_W0_HI;
            words_in     = '0;
            first_bad_in = 1'b0;
         end else begin
            // position outside the frame: drop the byte and restart
            crc_in       = CRC_INIT;
            pos_in       = POS_W0_HI;
            words_in     = '0;
            first_bad_in = 1'b0;
         end
      end
   end

   // Load the result register on a frame end, drop it once transferred.
   assign rsp_valid_in = emit ? 1'b1 : (rsp_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_MEASURE;
         s1_valid_ff  <= 1'b0;
         crc_ff       <= CRC_INIT;
         pos_ff       <= POS_W0_HI;
         words_ff     <= '0;
         first_bad_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         s1_valid_ff  <= s1_valid_in;
         crc_ff       <= crc_in;
         pos_ff       <= pos_in;
         words_ff     <= words_in;
         first_bad_ff <= first_bad_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         s1_byte_ff <= req_chan.rx_byte;
      end
      if (emit) begin
         rsp_status_ff <= rsp_status_in;
         rsp_value_ff  <= rsp_value_in;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.frame_status = rsp_status_ff;
   assign rsp_chan.frame_value  = rsp_value_ff;

   // The sequencer never leaves the frame it is in.
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      (pos_ff <= POS_W1_CRC) && (mode_ff == MODE_MEASURE || pos_ff <= POS_W0_CRC))
      else $error("frame position outside the frame");

   // A result is only produced by a CRC byte.
   a_emit_pos: assert property (@(posedge clock) disable iff (reset)
      emit |-> (pos_ff == POS_W0_CRC || pos_ff == POS_W1_CRC))
      else $error("result raised on a data byte");

   // A failed frame carries a zero value.
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != STATUS_OK) |-> (rsp_value_ff == '0))
      else $error("non-zero value on a CRC error");

   // Status frames never report a second-word failure.
   a_status_mode: assert property (@(posedge clock) disable iff (reset)
      (emit && mode_ff == MODE_STATUS) |-> (rsp_status_in != STATUS_SECOND_BAD))
      else $error("second-word error in status mode");

   // A mode write restarts the frame.
   a_cfg_restart: assert property (@(posedge clock) disable iff (reset)
      csr_wr_en |=> (pos_ff == POS_W0_HI && crc_ff == CRC_INIT && !first_bad_ff))
      else $error("frame state not restarted by mode write");

endmodule

FILE: rtl/core/sfcc_crc8_step.sv
// ----------------------------------------------------------------------------
// CRC-8 byte update
// Folds one byte into the running CRC, eight bit steps unrolled into XORs.
// ----------------------------------------------------------------------------
module sfcc_crc8_step
   import sfcc_pkg::*;
(
   input  crc_type  crc_cur,
   input  byte_type data_byte,
   output crc_type  crc_nxt
);

   always_comb begin
      crc_type c;
      c = crc_cur ^ data_byte;
      for (int k = 0; k < 8; k++) begin
         if ((c & CRC_MSB) != 8'h00) begin
            c = {c[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[6:0], 1'b0};
         end
      end
      crc_nxt = c;
   end

endmodule
